/* rtl/mwsd_pkg.sv */
// ----------------------------------------------------------------------------
// mwsd_pkg
// Shared types and constants of the moving window standard deviation block:
// sequencer states, command and status bundles, field widths.
// ----------------------------------------------------------------------------
package mwsd_pkg;

    // field widths of the stream payload
    localparam int SAMPLE_W  = 16;
    localparam int STD_W     = 15;
    localparam int COUNT_W   = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // default window length
    localparam int WINDOW_DEF = 25;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_UPDATE,
        ST_MULT,
        ST_SUB,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic ring_access;
        logic square;
        logic update;
        logic mult;
        logic sub;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

/* rtl/mwsd_ctrl.sv */
// ----------------------------------------------------------------------------
// mwsd_ctrl
// Sequencer: steps one sample through ring access, sum update, variance
// numerator, iterative square root and iterative division by the count.
// ----------------------------------------------------------------------------
module mwsd_ctrl #(
    parameter int WINDOW = mwsd_pkg::WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mwsd_pkg::t_status i_status,
    output mwsd_pkg::t_cmd    o_cmd
);
    import mwsd_pkg::*;

    localparam int CW   = $clog2(WINDOW + 1);
    localparam int RW   = (32 + 2 * CW) / 2;
    localparam int ITW  = $clog2(RW);

    t_state           r_state, n_state;
    logic [ITW-1:0]   r_iter, n_iter;

    // state and iteration counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ:   n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_MULT;
            ST_MULT:   n_state = ST_SUB;
            ST_SUB: begin
                n_state = ST_SQRT;
                n_iter  = ITW'(RW - 1);
            end
            ST_SQRT: begin
                if (r_iter == '0) begin
                    n_state = ST_DIV_INIT;
                end else begin
                    n_iter = r_iter - 1'b1;
                end
            end
            ST_DIV_INIT: begin
                n_state = ST_DIV;
                n_iter  = ITW'(RW - 1);
            end
            ST_DIV: begin
                if (r_iter == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_iter = r_iter - 1'b1;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_READ:     o_cmd.ring_access = 1'b1;
            ST_SQUARE:   o_cmd.square      = 1'b1;
            ST_UPDATE:   o_cmd.update      = 1'b1;
            ST_MULT:     o_cmd.mult        = 1'b1;
            ST_SUB:      o_cmd.sub         = 1'b1;
            ST_SQRT:     o_cmd.sqrt_step   = 1'b1;
            ST_DIV_INIT: o_cmd.div_init    = 1'b1;
            ST_DIV:      o_cmd.div_step    = 1'b1;
            ST_DONE:     o_cmd.emit        = i_status.out_free;
            default:     o_cmd             = '0;
        endcase
    end

endmodule

/* rtl/mwsd_datapath.sv */
// ----------------------------------------------------------------------------
// mwsd_datapath
// Sample ring, running sums, variance numerator, digit-by-digit square root,
// restoring division by the count, and the result register.
// ----------------------------------------------------------------------------
module mwsd_datapath #(
    parameter int WINDOW = mwsd_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mwsd_pkg::t_cmd                i_cmd,
    output mwsd_pkg::t_status             o_status,
    input  logic [mwsd_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mwsd_pkg::STD_W-1:0]    o_std_dev,
    output logic [mwsd_pkg::COUNT_W-1:0]  o_window_count
);
    import mwsd_pkg::*;

    localparam int CW  = $clog2(WINDOW + 1);
    localparam int SW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int S1W = SAMPLE_W + CW;
    localparam int S2W = 2 * SAMPLE_W + CW;
    localparam int VW  = 2 * SAMPLE_W + 2 * CW;
    localparam int RW  = VW / 2;

    // sample ring
    logic [SAMPLE_W-1:0] r_ring [WINDOW];

    logic [SW-1:0]       r_slot;
    logic [CW-1:0]       r_fill;
    logic                r_full;
    logic [S1W-1:0]      r_sum;
    logic [S2W-1:0]      r_sq_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_old;
    logic [2*SAMPLE_W-1:0] r_old_sq;
    logic [2*SAMPLE_W-1:0] r_new_sq;
    logic [VW-1:0]       r_prod;
    logic [VW-1:0]       r_s1_sq;
    logic [VW-1:0]       r_v;
    logic [RW-1:0]       r_root;
    logic [RW:0]         r_rem;
    logic [RW-1:0]       r_quot;
    logic [CW-1:0]       r_drem;
    logic                r_out_valid;
    logic [STD_W-1:0]    r_std_dev;
    logic [COUNT_W-1:0]  r_count;

    logic [SW-1:0]       n_slot_eff;
    logic [SW:0]         n_slot_inc;
    logic [RW+2:0]       n_rem_try;
    logic [RW+2:0]       n_trial;
    logic [CW:0]         n_div_try;
    logic [CW+COUNT_W-1:0] n_count_ext;

    // slot wrap guard and increment, square root and division trial values, count extension
    always_comb begin
        n_slot_eff  = (32'(r_slot) >= WINDOW) ? '0 : r_slot;
        n_slot_inc  = {1'b0, n_slot_eff} + 1'b1;
        n_rem_try   = {r_rem, r_v[VW-1:VW-2]};
        n_trial     = {1'b0, r_root, 2'b01};
        n_div_try   = {r_drem, r_quot[RW-1]};
        n_count_ext = {{COUNT_W{1'b0}}, r_fill};
    end

    // control registers: ring pointer, fill count, running sums, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sq_sum    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_slot <= (32'(n_slot_inc) >= WINDOW) ? '0 : n_slot_inc[SW-1:0];
                if (32'(r_fill) >= WINDOW) begin
                    r_fill <= CW'(WINDOW);
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.update) begin
                r_sum    <= r_sum - S1W'(r_old) + S1W'(r_sample);
                r_sq_sum <= r_sq_sum - S2W'(r_old_sq) + S2W'(r_new_sq);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ring write and registered read of the oldest sample
    logic [SW-1:0] r_acc_slot;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_slot <= n_slot_eff;
            r_sample   <= i_sample;
            r_full     <= (32'(r_fill) >= WINDOW);
        end
        if (i_cmd.ring_access) begin
            r_old <= r_full ? r_ring[r_acc_slot] : '0;
            r_ring[r_acc_slot] <= r_sample;
        end
    end

    // squares, variance numerator, square root and division
    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_old_sq <= r_old * r_old;
            r_new_sq <= r_sample * r_sample;
        end
        if (i_cmd.mult) begin
            r_prod  <= VW'(r_fill) * VW'(r_sq_sum);
            r_s1_sq <= VW'(r_sum) * VW'(r_sum);
        end
        if (i_cmd.sub) begin
            r_v    <= (r_prod >= r_s1_sq) ? (r_prod - r_s1_sq) : '0;
            r_root <= '0;
            r_rem  <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_v <= {r_v[VW-3:0], 2'b00};
            if (n_rem_try >= n_trial) begin
                r_rem  <= (RW+1)'(n_rem_try - n_trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= (RW+1)'(n_rem_try);
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_quot <= r_root;
            r_drem <= '0;
        end
        if (i_cmd.div_step) begin
            if (n_div_try >= {1'b0, r_fill}) begin
                r_drem <= CW'(n_div_try - {1'b0, r_fill});
                r_quot <= {r_quot[RW-2:0], 1'b1};
            end else begin
                r_drem <= n_div_try[CW-1:0];
                r_quot <= {r_quot[RW-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_std_dev <= r_quot[STD_W-1:0];
            r_count   <= n_count_ext[COUNT_W-1:0];
        end
    end

    // outputs
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_std_dev         = r_std_dev;
    assign o_window_count    = r_count;

endmodule

/* rtl/moving_window_std_dev_top.sv */
// ----------------------------------------------------------------------------
// moving_window_std_dev_top
// Moving window population standard deviation over the last WINDOW samples.
//
//   channel    dir   payload (tdata, lowest bit first)
//   s_axis     in    [15:0] sample
//   m_axis     out   [14:0] std_dev, [19:15] window_count, [23:20] zero
//
// The result of a sample is set by the square root and the division over RW = 16 + clog2(WINDOW+1)
// (21 at WINDOW 25) bits, one bit per cycle.
// A new sample is taken only after the previous one has left the sequencer.
// Reset clears the ring pointer, fill count and sums; the ring needs no clearing.
// A stalled result waits in the output register while the next sample is taken.
// ----------------------------------------------------------------------------
module moving_window_std_dev_top #(
    parameter int WINDOW = mwsd_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [mwsd_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // sample
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [mwsd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata   // std_dev, window_count
);
    import mwsd_pkg::*;

    t_cmd               w_cmd;
    t_status            w_status;
    logic [STD_W-1:0]   w_std_dev;
    logic [COUNT_W-1:0] w_count;

    // sequencer
    mwsd_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    mwsd_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_sample       (i_s_axis_tdata[SAMPLE_W-1:0]),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_std_dev      (w_std_dev),
        .o_window_count (w_count)
    );

    // result packing
    assign o_m_axis_tdata = {{(OUT_DATA_W - STD_W - COUNT_W){1'b0}}, w_count, w_std_dev};

endmodule
